[design/vnt_pkg.sv]
// Shared types and constants for the value-noise turbulence block.
`default_nettype none
package vnt_pkg;

    // Map geometry defaults (log2 of columns and rows).
    localparam int MAP_WIDTH_LOG2_DEF  = 8;
    localparam int MAP_HEIGHT_LOG2_DEF = 8;

    // Fixed field widths.
    localparam int COORD_W = 8;
    localparam int TEXEL_W = 8;
    localparam int GRAY_W  = 8;
    localparam int SHIFT_W = 4;

    // Datapath widths: weight up to 2^15, row sum up to 255 * 2^15.
    localparam int WT_W  = 16;
    localparam int ROW_W = 23;
    localparam int MAC_W = WT_W + ROW_W;
    localparam int ACC_W = MAC_W + 1;

    localparam logic [SHIFT_W-1:0] OCTAVE_SHIFT_RESET = 4'd4;

    // Command codes carried in tuser.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TURB = 1'b1;

    // Bilinear weights of one octave.
    typedef struct packed {
        logic [WT_W-1:0] wx_hi;   // fx, weight of column cx
        logic [WT_W-1:0] wx_lo;   // S - fx, weight of column cx-1
        logic [WT_W-1:0] wy_hi;   // fy, weight of row cy
        logic [WT_W-1:0] wy_lo;   // S - fy, weight of row cy-1
    } octave_wt_t;

    // Which of the four cells to address.
    typedef struct packed {
        logic lo_x;   // use column cx-1
        logic lo_y;   // use row cy-1
    } corner_t;

    // Control of the shared multiply-accumulate unit.
    typedef struct packed {
        logic en;
        logic clear;
    } mac_ctrl_t;

endpackage
`default_nettype wire

[design/vnt_ram.sv]
// Generic single-port RAM with registered read.
`default_nettype none
module vnt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[design/vnt_octave.sv]
// Cell address and bilinear weights of one octave.
`default_nettype none
module vnt_octave #(
    parameter int MAP_WIDTH_LOG2  = vnt_pkg::MAP_WIDTH_LOG2_DEF,
    parameter int MAP_HEIGHT_LOG2 = vnt_pkg::MAP_HEIGHT_LOG2_DEF
) (
    input  wire logic [vnt_pkg::COORD_W-1:0]             x,
    input  wire logic [vnt_pkg::COORD_W-1:0]             y,
    input  wire logic [vnt_pkg::SHIFT_W-1:0]             k,
    input  wire vnt_pkg::corner_t                        corner,
    output logic [MAP_WIDTH_LOG2+MAP_HEIGHT_LOG2-1:0]    addr,
    output vnt_pkg::octave_wt_t                          wt
);
    import vnt_pkg::*;

    logic [WT_W-1:0]            size;
    logic [WT_W-1:0]            mask;
    logic [WT_W-1:0]            fx;
    logic [WT_W-1:0]            fy;
    logic [MAP_WIDTH_LOG2-1:0]  cx;
    logic [MAP_HEIGHT_LOG2-1:0] cy;
    logic [MAP_WIDTH_LOG2-1:0]  col;
    logic [MAP_HEIGHT_LOG2-1:0] row;

    assign size = WT_W'(1) << k;
    assign mask = size - WT_W'(1);
    assign fx   = WT_W'(x) & mask;
    assign fy   = WT_W'(y) & mask;

    // Cell index wraps on the map size.
    assign cx = MAP_WIDTH_LOG2'(x >> k);
    assign cy = MAP_HEIGHT_LOG2'(y >> k);

    assign col = corner.lo_x ? (cx - MAP_WIDTH_LOG2'(1))  : cx;
    assign row = corner.lo_y ? (cy - MAP_HEIGHT_LOG2'(1)) : cy;

    assign addr = {row, col};

    assign wt.wx_hi = fx;
    assign wt.wx_lo = size - fx;
    assign wt.wy_hi = fy;
    assign wt.wy_lo = size - fy;

endmodule
`default_nettype wire

[design/vnt_mac.sv]
// Shared multiply-accumulate unit.
`default_nettype none
module vnt_mac (
    input  wire logic                      clk,
    input  wire vnt_pkg::mac_ctrl_t        ctrl,
    input  wire logic [vnt_pkg::WT_W-1:0]  a,
    input  wire logic [vnt_pkg::ROW_W-1:0] b,
    output logic      [vnt_pkg::MAC_W-1:0] sum
);
    import vnt_pkg::*;

    logic [MAC_W-1:0] prod;
    logic [MAC_W-1:0] sum_reg;
    logic [MAC_W-1:0] sum_next;

    assign prod     = MAC_W'(a) * MAC_W'(b);
    assign sum_next = (ctrl.clear ? '0 : sum_reg) + prod;

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule
`default_nettype wire

[design/value_noise_turbulence.sv]
// Top level of the value-noise turbulence block: sequencer, map and accumulator.
// Input stream (s_*): one transaction per command; tuser = command (0 loads one
//   texel, 1 computes one pixel); tdata = pixel_x [7:0], pixel_y [15:8], texel [23:16].
// Output stream (m_*): one transaction per compute command, tdata = gray [7:0].
// Config channel (cfg_*): writes octave_shift (4 bits); always ready. Write it
//   only while the block is idle.
// A load is written into the map at its acceptance edge; the block stays ready.
// A compute runs 8 steps per octave over (octave_shift + 1) octaves, then posts
//   its result from the done state: m_tvalid rises and s_tready returns at the
//   same edge. The single map read port (four texels per octave) and the single
//   multiply-accumulate unit (six products per octave) share one step sequencer.
// Reset: rst_n clears the sequencer and the output valid and sets octave_shift
//   to 4. The noise map is not cleared; load every texel a compute will read.
// Stall: the result sits in an output register and the next command is accepted
//   while it waits; a finished compute holds in its done state until that
//   register is free, and s_tready stays low meanwhile.
`default_nettype none
module value_noise_turbulence #(
    parameter int MAP_WIDTH_LOG2  = vnt_pkg::MAP_WIDTH_LOG2_DEF,
    parameter int MAP_HEIGHT_LOG2 = vnt_pkg::MAP_HEIGHT_LOG2_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // input stream
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [23:0]                 s_tdata,   // pixel_x, pixel_y, texel
    input  wire logic                        s_tuser,   // command
    // output stream
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [vnt_pkg::GRAY_W-1:0]       m_tdata,   // gray
    // config
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [vnt_pkg::SHIFT_W-1:0] cfg_data   // octave_shift
);
    import vnt_pkg::*;

    localparam int ADDR_W = MAP_WIDTH_LOG2 + MAP_HEIGHT_LOG2;

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // Steps within one octave
    localparam logic [2:0] STEP_RD_A   = 3'd0;  // read (cx,   cy)
    localparam logic [2:0] STEP_RD_B   = 3'd1;  // read (cx-1, cy),   mac = fx*t
    localparam logic [2:0] STEP_RD_C   = 3'd2;  // read (cx,   cy-1), mac += (S-fx)*t
    localparam logic [2:0] STEP_RD_D   = 3'd3;  // read (cx-1, cy-1), save row A, mac = fx*t
    localparam logic [2:0] STEP_ROW_B  = 3'd4;  // mac += (S-fx)*t
    localparam logic [2:0] STEP_COL_A  = 3'd5;  // save row B, mac = fy*rowA
    localparam logic [2:0] STEP_COL_B  = 3'd6;  // mac += (S-fy)*rowB
    localparam logic [2:0] STEP_ACC    = 3'd7;  // acc = 2*acc + v

    logic [1:0]          state_reg, state_next;
    logic [2:0]          step_reg, step_next;
    logic [SHIFT_W-1:0]  k_reg, k_next;
    logic [SHIFT_W-1:0]  octave_shift_reg;
    logic [COORD_W-1:0]  x_reg, y_reg;
    logic [ROW_W-1:0]    rowa_reg, rowb_reg;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic                out_valid_reg;
    logic [GRAY_W-1:0]   out_data_reg;

    logic                in_fire;
    logic                load_fire;
    logic                turb_fire;
    logic                out_free;
    logic                post;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   oct_addr;
    logic [ADDR_W-1:0]   ram_addr;
    logic [TEXEL_W-1:0]  ram_rdata;
    corner_t             corner;
    octave_wt_t          wt;
    mac_ctrl_t           mac_ctrl;
    logic [WT_W-1:0]     mac_a;
    logic [ROW_W-1:0]    mac_b;
    logic [MAC_W-1:0]    mac_sum;
    logic [4:0]          out_shift;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;
    assign load_fire = in_fire && (s_tuser == CMD_LOAD);
    assign turb_fire = in_fire && (s_tuser == CMD_TURB);
    assign out_free  = !out_valid_reg || m_tready;

    // Map address: load address while idle, octave cell otherwise
    assign wr_addr  = {MAP_HEIGHT_LOG2'(s_tdata[15:8]), MAP_WIDTH_LOG2'(s_tdata[7:0])};
    assign ram_addr = (state_reg == ST_IDLE) ? wr_addr : oct_addr;

    vnt_ram #(
        .WIDTH (TEXEL_W),
        .DEPTH (1 << ADDR_W)
    ) u_map (
        .clk   (clk),
        .we    (load_fire),
        .addr  (ram_addr),
        .wdata (s_tdata[23:16]),
        .rdata (ram_rdata)
    );

    vnt_octave #(
        .MAP_WIDTH_LOG2  (MAP_WIDTH_LOG2),
        .MAP_HEIGHT_LOG2 (MAP_HEIGHT_LOG2)
    ) u_octave (
        .x      (x_reg),
        .y      (y_reg),
        .k      (k_reg),
        .corner (corner),
        .addr   (oct_addr),
        .wt     (wt)
    );

    vnt_mac u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .a    (mac_a),
        .b    (mac_b),
        .sum  (mac_sum)
    );

    // Corner and MAC operand select per step
    always_comb
    begin
        corner        = '{lo_x: 1'b0, lo_y: 1'b0};
        mac_ctrl      = '{en: 1'b0, clear: 1'b0};
        mac_a         = wt.wx_hi;
        mac_b         = ROW_W'(ram_rdata);
        unique case (step_reg)
            STEP_RD_A:
            begin
                corner = '{lo_x: 1'b0, lo_y: 1'b0};
            end
            STEP_RD_B:
            begin
                corner   = '{lo_x: 1'b1, lo_y: 1'b0};
                mac_ctrl = '{en: 1'b1, clear: 1'b1};
                mac_a    = wt.wx_hi;
            end
            STEP_RD_C:
            begin
                corner   = '{lo_x: 1'b0, lo_y: 1'b1};
                mac_ctrl = '{en: 1'b1, clear: 1'b0};
                mac_a    = wt.wx_lo;
            end
            STEP_RD_D:
            begin
                corner   = '{lo_x: 1'b1, lo_y: 1'b1};
                mac_ctrl = '{en: 1'b1, clear: 1'b1};
                mac_a    = wt.wx_hi;
            end
            STEP_ROW_B:
            begin
                mac_ctrl = '{en: 1'b1, clear: 1'b0};
                mac_a    = wt.wx_lo;
            end
            STEP_COL_A:
            begin
                mac_ctrl = '{en: 1'b1, clear: 1'b1};
                mac_a    = wt.wy_hi;
                mac_b    = rowa_reg;
            end
            STEP_COL_B:
            begin
                mac_ctrl = '{en: 1'b1, clear: 1'b0};
                mac_a    = wt.wy_lo;
                mac_b    = rowb_reg;
            end
            STEP_ACC:
            begin
                mac_ctrl = '{en: 1'b0, clear: 1'b0};
            end
            default:
            begin
                mac_ctrl = '{en: 1'b0, clear: 1'b0};
            end
        endcase
        if (state_reg != ST_RUN)
        begin
            mac_ctrl = '{en: 1'b0, clear: 1'b0};
        end
    end

    // Octaves run from the smallest size up; doubling the sum each octave
    // weights octave k by 2^(shift-k).
    assign acc_next  = {acc_reg[ACC_W-2:0], 1'b0} + ACC_W'(mac_sum);
    assign out_shift = {octave_shift_reg, 1'b1};
    assign post      = (state_reg == ST_DONE) && out_free;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (turb_fire)
                begin
                    state_next = ST_RUN;
                    step_next  = STEP_RD_A;
                    k_next     = '0;
                end
            end
            ST_RUN:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == STEP_ACC)
                begin
                    if (k_reg == octave_shift_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        k_next = k_reg + SHIFT_W'(1);
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= STEP_RD_A;
            k_reg            <= '0;
            octave_shift_reg <= OCTAVE_SHIFT_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            k_reg     <= k_next;
            if (cfg_valid && cfg_ready)
            begin
                octave_shift_reg <= cfg_data;
            end
            if (post)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (turb_fire)
        begin
            x_reg   <= s_tdata[7:0];
            y_reg   <= s_tdata[15:8];
            acc_reg <= '0;
        end
        if (state_reg == ST_RUN)
        begin
            if (step_reg == STEP_RD_D)
            begin
                rowa_reg <= mac_sum[ROW_W-1:0];
            end
            if (step_reg == STEP_COL_A)
            begin
                rowb_reg <= mac_sum[ROW_W-1:0];
            end
            if (step_reg == STEP_ACC)
            begin
                acc_reg <= acc_next;
            end
        end
        if (post)
        begin
            out_data_reg <= GRAY_W'(acc_reg >> out_shift);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire

[design/vnt_checker.sv]
// Port-level checks of the value-noise turbulence block, bound to the top level.
`default_nettype none
module vnt_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      s_tvalid,
    input wire logic                      s_tready,
    input wire logic                      s_tuser,
    input wire logic                      m_tvalid,
    input wire logic                      m_tready,
    input wire logic [vnt_pkg::GRAY_W-1:0] m_tdata
);
    import vnt_pkg::*;

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A compute transaction makes the block busy.
    a_turb_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == CMD_TURB) |=> !s_tready)
        else $error("ready right after compute transaction");

    // A load transaction leaves the block ready.
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == CMD_LOAD) |=> s_tready)
        else $error("not ready after load transaction");

    // No result can appear in the cycle after a compute starts.
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == CMD_TURB) && !m_tvalid |=> !m_tvalid)
        else $error("result too early");

endmodule

bind value_noise_turbulence vnt_checker u_vnt_checker (.*);
`default_nettype wire
